### rtl/device_quirk_match_table_top_macros.svh
// Assertion macros for the device quirk match table.
// Used by device_quirk_match_table_top; no other dependencies.
`ifndef DEVICE_QUIRK_MATCH_TABLE_TOP_MACROS_SVH
`define DEVICE_QUIRK_MATCH_TABLE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DQMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqmt: same-cycle check failed");
`define DQMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqmt: next-cycle check failed");
`else
`define DQMT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DQMT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/dqmt_pkg.sv
// Shared types and constants of the device quirk match table.
// No dependencies; used by every other file of the block but the assertion macro header.
package dqmt_pkg;

   localparam int CODE_W    = 16;
   localparam int ID_W      = 16;
   localparam int SLOT_W    = 3;
   localparam int IDX_OUT_W = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic [CODE_W-1:0] NONE_CODE_RST   = 16'd0;
   localparam logic [CODE_W-1:0] VENDOR_ONLY_RST = 16'd1;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NONE_CODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VENDOR_ONLY = 1'd1;

   typedef struct packed {
      logic [ID_W-1:0] bus_id;
      logic [ID_W-1:0] vendor_id;
      logic [ID_W-1:0] product_id;
      logic [ID_W-1:0] low_rev;
      logic [ID_W-1:0] high_rev;
   } key_type;

   typedef struct packed {
      logic              operation;
      key_type           key;
      logic [CODE_W-1:0] quirk_code;
      logic [SLOT_W-1:0] slot_index;
   } item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic pick;
      logic write;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic op_write;
      logic full;
      logic rsp_free;
   } stat_type;

endpackage

### rtl/dqmt_if.sv
// Channel interfaces of the device quirk match table: request, response, CSR write.
// Depends on dqmt_pkg for field widths.
interface dqmt_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [dqmt_pkg::ID_W-1:0]    bus_id;
   logic [dqmt_pkg::ID_W-1:0]    vendor_id;
   logic [dqmt_pkg::ID_W-1:0]    product_id;
   logic [dqmt_pkg::ID_W-1:0]    version_or_low_rev;
   logic [dqmt_pkg::ID_W-1:0]    high_rev;
   logic [dqmt_pkg::CODE_W-1:0]  quirk_code;
   logic [dqmt_pkg::SLOT_W-1:0]  slot_index;

   modport source (output valid, operation, bus_id, vendor_id, product_id,
                   version_or_low_rev, high_rev, quirk_code, slot_index, input ready);
   modport sink (input valid, operation, bus_id, vendor_id, product_id,
                 version_or_low_rev, high_rev, quirk_code, slot_index, output ready);
endinterface

interface dqmt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic                           status;
   logic [dqmt_pkg::IDX_OUT_W-1:0] entry_index;

   modport source (output valid, found, status, entry_index, input ready);
   modport sink (input valid, found, status, entry_index, output ready);
endinterface

interface dqmt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [dqmt_pkg::CSR_IDX_W-1:0] index;
   logic [dqmt_pkg::CODE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/dqmt_datapath.sv
// Datapath of the device quirk match table: key and slot memories, scan counter,
// match logic, CSRs and result register. Depends on dqmt_pkg.
module dqmt_datapath #(
   parameter int ENTRIES = 384,
   parameter int SLOTS   = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dqmt_pkg::cmd_type              cmd,
   output dqmt_pkg::stat_type             stat,
   input  dqmt_pkg::item_type             req_item,
   input  logic                           csr_we,
   input  logic [dqmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dqmt_pkg::CODE_W-1:0]    csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic                           rsp_status,
   output logic [dqmt_pkg::IDX_OUT_W-1:0] rsp_entry_index
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef logic [SLOTS-1:0][dqmt_pkg::CODE_W-1:0] row_type;

   dqmt_pkg::key_type key_mem_ff [ENTRIES];
   row_type           row_mem_ff [ENTRIES];
   dqmt_pkg::key_type key_rd_ff;
   row_type           row_rd_ff;

   dqmt_pkg::item_type          item_ff;
   logic [dqmt_pkg::CODE_W-1:0] none_code_ff, vendor_only_ff;
   logic [IDX_W-1:0]            cnt_ff, eval_idx_ff, match_idx_ff, free_idx_ff, tgt_idx_ff;
   logic                        eval_vld_ff, hit_ff, match_found_ff, free_found_ff, full_ff;
   logic                        rsp_vld_ff, rsp_found_ff, rsp_status_ff;
   logic [dqmt_pkg::IDX_OUT_W-1:0] rsp_idx_ff;

   logic             has_quirk, has_vendor_only, key_hit, is_free, is_exact;
   logic             zero_key, full_comb, mem_we, key_we;
   logic [IDX_W-1:0] tgt_comb, rd_addr, wr_addr;
   dqmt_pkg::key_type key_wr;
   row_type          row_wr;

   always_comb begin
      has_quirk       = 1'b0;
      has_vendor_only = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         if (row_rd_ff[s] == item_ff.quirk_code) has_quirk = 1'b1;
         if (row_rd_ff[s] == vendor_only_ff) has_vendor_only = 1'b1;
      end
      key_hit = (key_rd_ff.bus_id == item_ff.key.bus_id)
              && (key_rd_ff.vendor_id == item_ff.key.vendor_id)
              && (key_rd_ff.low_rev <= item_ff.key.low_rev)
              && (key_rd_ff.high_rev >= item_ff.key.low_rev)
              && ((key_rd_ff.product_id == item_ff.key.product_id)
                  || ((key_rd_ff.product_id == '0) && has_vendor_only));
      is_free   = (key_rd_ff == '0);
      is_exact  = (key_rd_ff == item_ff.key);
      zero_key  = (item_ff.key == '0);
      full_comb = !zero_key && !match_found_ff && !free_found_ff;
      if (zero_key) begin
         tgt_comb = LAST_IDX;
      end else if (match_found_ff) begin
         tgt_comb = match_idx_ff;
      end else begin
         tgt_comb = free_idx_ff;
      end
   end

   always_comb begin
      row_wr = row_rd_ff;
      for (int s = 0; s < SLOTS; s++) begin
         if (int'(item_ff.slot_index) == s) row_wr[s] = item_ff.quirk_code;
      end
      if (cmd.clear) begin
         mem_we  = 1'b1;
         key_we  = 1'b1;
         wr_addr = cnt_ff;
         key_wr  = '0;
         row_wr  = '0;
      end else begin
         mem_we  = cmd.write;
         key_we  = cmd.write && !zero_key;
         wr_addr = tgt_idx_ff;
         key_wr  = item_ff.key;
      end
      rd_addr = cmd.pick ? tgt_comb : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem_ff[wr_addr] <= key_wr;
      if (mem_we) row_mem_ff[wr_addr] <= row_wr;
      key_rd_ff <= key_mem_ff[rd_addr];
      row_rd_ff <= row_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         eval_vld_ff    <= 1'b0;
         hit_ff         <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         none_code_ff   <= dqmt_pkg::NONE_CODE_RST;
         vendor_only_ff <= dqmt_pkg::VENDOR_ONLY_RST;
         rsp_vld_ff     <= 1'b0;
      end else begin
         if (cmd.clear || cmd.scan) begin
            cnt_ff <= (cnt_ff == LAST_IDX) ? '0 : cnt_ff + 1'b1;
         end
         eval_vld_ff <= cmd.scan;
         if (cmd.load) begin
            hit_ff         <= 1'b0;
            match_found_ff <= 1'b0;
            free_found_ff  <= 1'b0;
         end else if (eval_vld_ff) begin
            if (key_hit && has_quirk && (item_ff.quirk_code != none_code_ff)) hit_ff <= 1'b1;
            if (is_exact && !match_found_ff) match_found_ff <= 1'b1;
            if (is_free && !free_found_ff) free_found_ff <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               dqmt_pkg::CSR_NONE_CODE:   none_code_ff   <= csr_data;
               dqmt_pkg::CSR_VENDOR_ONLY: vendor_only_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.finish && stat.rsp_free) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_item;
      eval_idx_ff <= cnt_ff;
      if (eval_vld_ff && is_exact && !match_found_ff) match_idx_ff <= eval_idx_ff;
      if (eval_vld_ff && is_free && !free_found_ff) free_idx_ff <= eval_idx_ff;
      if (cmd.pick) begin
         tgt_idx_ff <= tgt_comb;
         full_ff    <= full_comb;
      end
      if (cmd.finish && stat.rsp_free) begin
         if (item_ff.operation == dqmt_pkg::OP_WRITE) begin
            rsp_found_ff  <= 1'b0;
            rsp_status_ff <= full_ff ? dqmt_pkg::STATUS_FULL : dqmt_pkg::STATUS_OK;
            rsp_idx_ff    <= full_ff ? '0 : dqmt_pkg::IDX_OUT_W'(tgt_idx_ff);
         end else begin
            rsp_found_ff  <= hit_ff;
            rsp_status_ff <= dqmt_pkg::STATUS_OK;
            rsp_idx_ff    <= '0;
         end
      end
   end

   assign stat.cnt_last = (cnt_ff == LAST_IDX);
   assign stat.op_write = (item_ff.operation == dqmt_pkg::OP_WRITE);
   assign stat.full     = full_comb;
   assign stat.rsp_free = !rsp_vld_ff || rsp_ready;

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_idx_ff;

endmodule

### rtl/dqmt_ctrl.sv
// Control state machine of the device quirk match table.
// Depends on dqmt_pkg for the state, command and status types.
module dqmt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dqmt_pkg::stat_type stat,
   output dqmt_pkg::cmd_type  cmd
);

   dqmt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqmt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         dqmt_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.cnt_last) state_in = dqmt_pkg::ST_IDLE;
         end
         dqmt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dqmt_pkg::ST_SCAN;
            end
         end
         dqmt_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.cnt_last) state_in = dqmt_pkg::ST_DRAIN;
         end
         dqmt_pkg::ST_DRAIN: begin
            state_in = stat.op_write ? dqmt_pkg::ST_PICK : dqmt_pkg::ST_DONE;
         end
         dqmt_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = stat.full ? dqmt_pkg::ST_DONE : dqmt_pkg::ST_WRITE;
         end
         dqmt_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = dqmt_pkg::ST_DONE;
         end
         dqmt_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
            if (stat.rsp_free) state_in = dqmt_pkg::ST_IDLE;
         end
         default: begin
            state_in = dqmt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/device_quirk_match_table_top.sv
// Top level of the device quirk match table: controller, datapath and channel glue.
// Depends on dqmt_pkg, dqmt_if, dqmt_ctrl, dqmt_datapath and the assertion macro header.
`include "device_quirk_match_table_top_macros.svh"

// The block keeps ENTRIES device entries (key plus SLOTS quirk codes) in two memories, each
// with one read and one write port, and handles one request at a time. Every request reads
// all entries in order, one per cycle through the memory read port, and a write adds a
// read-modify-write of the chosen entry's slot row. After reset a clearing pass zeroes
// both memories; no request is accepted during it, while CSR writes are always taken.
// A new request is accepted once the previous one has been posted to the response
// register, even if that response has not been taken yet.
module device_quirk_match_table_top #(
   parameter int ENTRIES = 384,
   parameter int SLOTS   = 8
) (
   input logic        clock,
   input logic        reset,
   dqmt_req_if.sink   req_chan,
   dqmt_rsp_if.source rsp_chan,
   dqmt_csr_if.sink   csr_chan
);

   dqmt_pkg::cmd_type  cmd;
   dqmt_pkg::stat_type stat;
   dqmt_pkg::item_type req_item;
   logic               req_ready;

   assign req_item.operation        = req_chan.operation;
   assign req_item.key.bus_id       = req_chan.bus_id;
   assign req_item.key.vendor_id    = req_chan.vendor_id;
   assign req_item.key.product_id   = req_chan.product_id;
   assign req_item.key.low_rev      = req_chan.version_or_low_rev;
   assign req_item.key.high_rev     = req_chan.high_rev;
   assign req_item.quirk_code       = req_chan.quirk_code;
   assign req_item.slot_index       = req_chan.slot_index;
   assign req_chan.ready            = req_ready;
   assign csr_chan.ready            = 1'b1;

   dqmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dqmt_datapath #(
      .ENTRIES (ENTRIES),
      .SLOTS   (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_item        (req_item),
      .csr_we          (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_found       (rsp_chan.found),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_index (rsp_chan.entry_index)
   );

   `DQMT_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `DQMT_ASSERT_IMPL(a_no_accept_while_clearing, clock, reset, cmd.clear, !req_chan.ready)
   `DQMT_ASSERT_IMPL(a_full_has_no_entry, clock, reset, rsp_chan.valid && (rsp_chan.status == dqmt_pkg::STATUS_FULL), (rsp_chan.entry_index == '0) && !rsp_chan.found)
   `DQMT_ASSERT_NEXT(a_result_posted, clock, reset, cmd.finish && stat.rsp_free, rsp_chan.valid)

endmodule

### bench/device_quirk_match_table_checker.sv
// Checker for the device quirk match table: watches the request, response and CSR channels,
// keeps its own copy of the entry table and compares every response with its prediction.
// Depends on dqmt_pkg and the channel interfaces in dqmt_if.
module device_quirk_match_table_checker #(
   parameter int ENTRIES = 384,
   parameter int SLOTS   = 8
) (
   input  logic clock,
   input  logic reset,
   dqmt_req_if  req_chan,
   dqmt_rsp_if  rsp_chan,
   dqmt_csr_if  csr_chan,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import dqmt_pkg::*;

   typedef struct packed {
      logic                 found;
      logic                 status;
      logic [IDX_OUT_W-1:0] entry_index;
   } answer_type;

   key_type           table_keys[ENTRIES];
   logic [CODE_W-1:0] table_codes[ENTRIES][SLOTS];
   logic [CODE_W-1:0] none_code;
   logic [CODE_W-1:0] vendor_only_code;
   answer_type        answers_due[$];
   int                mismatches;
   int                responses_seen;

   function automatic logic entry_holds(input int e, input logic [CODE_W-1:0] code);
      for (int s = 0; s < SLOTS; s++) begin
         if (table_codes[e][s] == code) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic entry_matches(input int e, input key_type probe);
      key_type k;
      k = table_keys[e];
      if (k.bus_id != probe.bus_id || k.vendor_id != probe.vendor_id ||
          k.low_rev > probe.low_rev || k.high_rev < probe.low_rev) return 1'b0;
      if (k.product_id != probe.product_id &&
          (k.product_id != '0 || !entry_holds(e, vendor_only_code))) return 1'b0;
      return 1'b1;
   endfunction

   function automatic answer_type table_answer(input item_type it);
      answer_type ans;
      int         row;
      ans = '0;
      row = -1;
      if (it.operation == OP_LOOKUP) begin
         if (it.quirk_code != none_code) begin
            for (int e = 0; e < ENTRIES; e++) begin
               if (entry_matches(e, it.key) && entry_holds(e, it.quirk_code)) begin
                  ans.found = 1'b1;
                  break;
               end
            end
         end
      end else begin
         if (it.key == '0) begin
            row = ENTRIES - 1;
         end else begin
            for (int e = 0; e < ENTRIES; e++) begin
               if (table_keys[e] == it.key) begin
                  row = e;
                  break;
               end
            end
            if (row < 0) begin
               for (int e = 0; e < ENTRIES; e++) begin
                  if (table_keys[e] == '0) begin
                     row = e;
                     table_keys[e] = it.key;
                     break;
                  end
               end
            end
         end
         if (row < 0) begin
            ans.status = STATUS_FULL;
         end else begin
            if (it.slot_index < SLOTS) table_codes[row][it.slot_index] = it.quirk_code;
            ans.status = STATUS_OK;
            ans.entry_index = IDX_OUT_W'(row);
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      item_type   it;
      answer_type want;
      answer_type got;
      if (reset) begin
         foreach (table_keys[e]) table_keys[e] = '0;
         foreach (table_codes[e, s]) table_codes[e][s] = '0;
         none_code = NONE_CODE_RST;
         vendor_only_code = VENDOR_ONLY_RST;
         answers_due.delete();
         mismatches = 0;
         responses_seen = 0;
      end else begin
         if (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1) begin
            case (csr_chan.index)
               CSR_NONE_CODE: begin
                  none_code = csr_chan.data;
               end
               CSR_VENDOR_ONLY: begin
                  vendor_only_code = csr_chan.data;
               end
               default: begin
               end
            endcase
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            it.operation      = req_chan.operation;
            it.key.bus_id     = req_chan.bus_id;
            it.key.vendor_id  = req_chan.vendor_id;
            it.key.product_id = req_chan.product_id;
            it.key.low_rev    = req_chan.version_or_low_rev;
            it.key.high_rev   = req_chan.high_rev;
            it.quirk_code     = req_chan.quirk_code;
            it.slot_index     = req_chan.slot_index;
            answers_due.push_back(table_answer(it));
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.found       = rsp_chan.found;
            got.status      = rsp_chan.status;
            got.entry_index = rsp_chan.entry_index;
            responses_seen++;
            if (answers_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: response %0d arrived with no request outstanding: found=%0b status=%0b entry=%0d",
                           $realtime, responses_seen, got.found, got.status, got.entry_index);
            end else begin
               want = answers_due.pop_front();
               if (got.found !== want.found || got.status !== want.status ||
                   got.entry_index !== want.entry_index) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%t: response %0d expected found=%0b status=%0b entry=%0d, got found=%0b status=%0b entry=%0d",
                              $realtime, responses_seen, want.found, want.status,
                              want.entry_index, got.found, got.status, got.entry_index);
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= answers_due.size();
   end

endmodule

### bench/device_quirk_match_table_top_tb.sv
// Top of the device quirk match table testbench: clock, reset, stimulus and the verdict.
// Depends on dqmt_pkg, dqmt_if, the block under test and device_quirk_match_table_checker.
module device_quirk_match_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dqmt_pkg::*;

   localparam int ENTRIES        = 384;
   localparam int SLOTS          = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = ENTRIES + 16;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   int       error_count;
   int       pending_count;
   int       req_idle_pct;
   int       rsp_idle_pct;
   int       quiet_cycles;
   item_type known_writes[$];

   dqmt_req_if req_chan ();
   dqmt_rsp_if rsp_chan ();
   dqmt_csr_if csr_chan ();

   device_quirk_match_table_top #(
      .ENTRIES (ENTRIES),
      .SLOTS   (SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   device_quirk_match_table_checker #(
      .ENTRIES (ENTRIES),
      .SLOTS   (SLOTS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
          (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("device_quirk_match_table_top_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic item_type make_item(input logic op, input logic [ID_W-1:0] bus,
                                          input logic [ID_W-1:0] vendor,
                                          input logic [ID_W-1:0] product,
                                          input logic [ID_W-1:0] ver_lo,
                                          input logic [ID_W-1:0] hi,
                                          input logic [CODE_W-1:0] quirk,
                                          input logic [SLOT_W-1:0] slot);
      item_type it;
      it.operation      = op;
      it.key.bus_id     = bus;
      it.key.vendor_id  = vendor;
      it.key.product_id = product;
      it.key.low_rev    = ver_lo;
      it.key.high_rev   = hi;
      it.quirk_code     = quirk;
      it.slot_index     = slot;
      return it;
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hFFFF;
         3, 4, 5, 6: return CODE_W'($urandom_range(15));
         7: return 16'h8000;
         default: return CODE_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic key_type fresh_key();
      key_type          k;
      logic [ID_W-1:0]  a;
      logic [ID_W-1:0]  b;
      int               roll;
      case ($urandom_range(3))
         0: k.bus_id = 16'h0003;
         1: k.bus_id = 16'h0005;
         2: k.bus_id = 16'hFFFF;
         default: k.bus_id = ID_W'($urandom_range(65535));
      endcase
      case ($urandom_range(3))
         0: k.vendor_id = 16'h1234;
         1: k.vendor_id = 16'h0000;
         2: k.vendor_id = 16'hFFFF;
         default: k.vendor_id = ID_W'($urandom_range(65535));
      endcase
      k.product_id = ($urandom_range(99) < 25) ? '0 : ID_W'($urandom_range(65535));
      a = ID_W'($urandom_range(65535));
      b = ID_W'($urandom_range(65535));
      roll = $urandom_range(99);
      if (roll < 10) begin
         k.low_rev  = 16'h0000;
         k.high_rev = 16'hFFFF;
      end else if (roll < 20) begin
         k.low_rev  = (a > b) ? a : b;
         k.high_rev = (a > b) ? b : a;
      end else begin
         k.low_rev  = (a > b) ? b : a;
         k.high_rev = (a > b) ? a : b;
      end
      return k;
   endfunction

   function automatic item_type random_item();
      item_type it;
      item_type known_one;
      int       roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         it.operation      = 1'($urandom_range(1));
         it.key.bus_id     = ID_W'($urandom_range(65535));
         it.key.vendor_id  = ID_W'($urandom_range(65535));
         it.key.product_id = ID_W'($urandom_range(65535));
         it.key.low_rev    = ID_W'($urandom_range(65535));
         it.key.high_rev   = ID_W'($urandom_range(65535));
         it.quirk_code     = CODE_W'($urandom_range(65535));
         it.slot_index     = SLOT_W'($urandom_range(7));
      end else if (roll < 68 || known_writes.size() == 0) begin
         it.operation = OP_WRITE;
         if (known_writes.size() == 0 || $urandom_range(99) < 75)
            it.key = fresh_key();
         else
            it.key = known_writes[$urandom_range(known_writes.size() - 1)].key;
         it.quirk_code = pick_code();
         it.slot_index = SLOT_W'($urandom_range(7));
      end else begin
         known_one    = known_writes[$urandom_range(known_writes.size() - 1)];
         it.operation = OP_LOOKUP;
         it.key       = known_one.key;
         if ($urandom_range(99) < 25) it.key.product_id = ID_W'($urandom_range(65535));
         case ($urandom_range(9))
            0: it.key.low_rev = known_one.key.low_rev;
            1: it.key.low_rev = known_one.key.high_rev;
            2, 3, 4, 5, 6: begin
               if (known_one.key.low_rev <= known_one.key.high_rev)
                  it.key.low_rev = ID_W'($urandom_range(known_one.key.high_rev,
                                                        known_one.key.low_rev));
               else
                  it.key.low_rev = ID_W'($urandom_range(65535));
            end
            default: it.key.low_rev = ID_W'($urandom_range(65535));
         endcase
         it.key.high_rev = ID_W'($urandom_range(65535));
         it.quirk_code   = ($urandom_range(1) == 1) ? known_one.quirk_code : pick_code();
         it.slot_index   = SLOT_W'($urandom_range(7));
      end
      return it;
   endfunction

   task automatic send_item(input item_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.operation          <= it.operation;
      req_chan.bus_id             <= it.key.bus_id;
      req_chan.vendor_id          <= it.key.vendor_id;
      req_chan.product_id         <= it.key.product_id;
      req_chan.version_or_low_rev <= it.key.low_rev;
      req_chan.high_rev           <= it.key.high_rev;
      req_chan.quirk_code         <= it.quirk_code;
      req_chan.slot_index         <= it.slot_index;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (it.operation == OP_WRITE) known_writes.push_back(it);
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic configure(input logic [CODE_W-1:0] none_value,
                            input logic [CODE_W-1:0] vendor_only_value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= CSR_NONE_CODE;
      csr_chan.data  <= none_value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      @(negedge clock);
      csr_chan.index <= CSR_VENDOR_ONLY;
      csr_chan.data  <= vendor_only_value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      req_chan.valid              = 1'b0;
      req_chan.operation          = OP_LOOKUP;
      req_chan.bus_id             = '0;
      req_chan.vendor_id          = '0;
      req_chan.product_id         = '0;
      req_chan.version_or_low_rev = '0;
      req_chan.high_rev           = '0;
      req_chan.quirk_code         = '0;
      req_chan.slot_index         = '0;
      csr_chan.valid              = 1'b0;
      csr_chan.index              = CSR_NONE_CODE;
      csr_chan.data               = '0;
      quiet_cycles                = 0;
      req_idle_pct                = 30;
      rsp_idle_pct                = 63;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      configure(NONE_CODE_RST, VENDOR_ONLY_RST);

      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5678, 16'h0100, 16'h0, 16'h5, 3'd0));
      send_item(make_item(OP_WRITE, 16'h0003, 16'h1234, 16'h5678, 16'h0100, 16'h0200, 16'h5, 3'd0));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5678, 16'h0100, 16'h0, 16'h5, 3'd0));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5678, 16'h0200, 16'h0, 16'h5, 3'd0));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5678, 16'h00FF, 16'h0, 16'h5, 3'd0));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5678, 16'h0201, 16'h0, 16'h5, 3'd0));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5679, 16'h0150, 16'h0, 16'h5, 3'd0));
      send_item(make_item(OP_WRITE, 16'h0003, 16'h1234, 16'h5678, 16'h0100, 16'h0200, 16'hFFFF,
                          3'd7));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5678, 16'h0150, 16'h0, 16'hFFFF,
                          3'd0));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'h5678, 16'h0150, 16'h0, 16'h0, 3'd0));
      send_item(make_item(OP_WRITE, 16'h0003, 16'h1234, 16'h0000, 16'h0000, 16'hFFFF, 16'h9, 3'd1));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'hBEEF, 16'h0000, 16'h0, 16'h9, 3'd0));
      send_item(make_item(OP_WRITE, 16'h0003, 16'h1234, 16'h0000, 16'h0000, 16'hFFFF, 16'h1, 3'd2));
      send_item(make_item(OP_LOOKUP, 16'h0003, 16'h1234, 16'hBEEF, 16'hFFFF, 16'h0, 16'h9, 3'd0));
      send_item(make_item(OP_WRITE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7, 3'd3));
      send_item(make_item(OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h7, 3'd0));
      send_item(make_item(OP_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000,
                          3'd4));
      send_item(make_item(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h8000,
                          3'd0));
      send_item(make_item(OP_WRITE, 16'h0005, 16'h0000, 16'h0001, 16'h0300, 16'h0100, 16'h3, 3'd0));
      send_item(make_item(OP_LOOKUP, 16'h0005, 16'h0000, 16'h0001, 16'h0200, 16'h0, 16'h3, 3'd0));
      repeat (320) send_item(random_item());
      drain();

      configure(16'hFFFF, 16'h0000);
      req_idle_pct = 63;
      rsp_idle_pct = 30;
      repeat (320) send_item(random_item());
      drain();

      configure(CODE_W'($urandom_range(15, 2)), 16'hFFFF);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (310) send_item(random_item());
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("device_quirk_match_table_top_tb: done, clean");
      end else begin
         $display("device_quirk_match_table_top_tb: done, errors");
      end
      $finish;
   end

endmodule
